/* rtl/collection_tree_parent_selector_unit_assert.svh */
// Assertion macros used by the checker file.
`ifndef COLLECTION_TREE_PARENT_SELECTOR_UNIT_ASSERT_SVH
`define COLLECTION_TREE_PARENT_SELECTOR_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define CTPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ctps check failed");

// Check a property on every clock edge, reset included.
`define CTPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ctps check failed");

`endif

/* rtl/ctps_pkg.sv */
`default_nettype none
package ctps_pkg;

  // Index field width, large enough for the biggest supported table.
  localparam int unsigned IdxW = 6;

  localparam logic [15:0] NoAddr = 16'hffff;
  localparam logic [15:0] NoEtx  = 16'hffff;

  typedef enum logic [1:0] {
    OP_BEACON_RX   = 2'd0,
    OP_BEACON_TICK = 2'd1,
    OP_RELAY       = 2'd2,
    OP_UNUSED      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_ROUTE = 2'd1,
    ST_IGNORED  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP
  } state_e;

  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] mac;
    logic [15:0] parent;
    logic [15:0] etx;
  } entry_t;

  typedef struct packed {
    logic            vld;
    logic [IdxW-1:0] idx;
    logic [15:0]     etx;
  } pick_t;

  // Running results of one sweep along the cell chain.
  typedef struct packed {
    logic  tok;
    pick_t hit;
    pick_t free;
    pick_t worst;
    pick_t best;
  } sweep_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] idx;
    entry_t          data;
  } wr_t;

endpackage
`default_nettype wire

/* rtl/ctps_cell.sv */
`default_nettype none
module ctps_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctps_pkg::sweep_t sweep_i,
  input  logic [15:0]     key_i,
  input  ctps_pkg::wr_t   wr_i,
  output ctps_pkg::sweep_t sweep_o,
  output logic            valid_o,
  output ctps_pkg::entry_t entry_o
);
  import ctps_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic   valid_q;
  entry_t entry_q;
  sweep_t sweep_d, sweep_q;

  // Fold this entry into the running sweep results.
  always_comb begin
    sweep_d = sweep_i;
    if (valid_q && entry_q.addr == key_i) begin
      sweep_d.hit.vld = 1'b1;
      sweep_d.hit.idx = MyIdx;
    end
    if (!valid_q && !sweep_i.free.vld) begin
      sweep_d.free.vld = 1'b1;
      sweep_d.free.idx = MyIdx;
    end
    if (valid_q && entry_q.etx > sweep_i.worst.etx) begin
      sweep_d.worst.vld = 1'b1;
      sweep_d.worst.idx = MyIdx;
      sweep_d.worst.etx = entry_q.etx;
    end
    if (valid_q && entry_q.etx < sweep_i.best.etx) begin
      sweep_d.best.vld = 1'b1;
      sweep_d.best.idx = MyIdx;
      sweep_d.best.etx = entry_q.etx;
    end
  end

  // Hand the sweep to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else begin
      sweep_q <= sweep_d;
    end
  end

  // Hold the entry's valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i.en && wr_i.idx == MyIdx) begin
      valid_q <= 1'b1;
    end
  end

  // Store entry payload.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.idx == MyIdx) begin
      entry_q <= wr_i.data;
    end
  end

  assign sweep_o = sweep_q;
  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule
`default_nettype wire

/* rtl/collection_tree_parent_selector_unit.sv */
`default_nettype none
// Collection tree parent selector.
// Input channel: present operation_i and the beacon fields with start high; the
// item is taken at the edge where start is high and busy is low. busy stays high
// until the result is produced.
// Config: cfg_we_i writes cfg_wdata_i into self_addr (reset 1, zero means root);
// write only while busy is low and no result is pending.
// Output channel: done_o marks a one-cycle result on status_o, dest_mac_o,
// beacon_seq_o, frame_parent_o and frame_etx_o; it must be taken in that cycle.
// Each item runs one sweep through the chain of TableEntries cells,
// one cell per cycle, and done_o is registered once the sweep leaves the last
// cell; busy drops in that result cycle, so the next item can be taken at the
// edge that ends it. A new item is taken only after the last one is done.
// Reset: all table entries invalid, no parent, beacon counter zero, no result.
// The receiver cannot stall, so nothing waits on the output side.
module collection_tree_parent_selector_unit #(
  parameter int unsigned TableEntries = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [15:0] sender_addr_i,
  input  logic [15:0] src_mac_i,
  input  logic [15:0] adv_parent_i,
  input  logic [15:0] adv_etx_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] dest_mac_o,
  output logic [31:0] beacon_seq_o,
  output logic [15:0] frame_parent_o,
  output logic [15:0] frame_etx_o
);
  import ctps_pkg::*;

  localparam int unsigned IW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  state_e state_q, state_d;
  logic   go_q;
  op_e    op_q;
  logic [15:0] sender_q, mac_q, advp_q, adve_q, self_q;
  logic          known_q, known_d;
  logic [IW-1:0] pslot_q, pslot_d;
  logic [31:0]   cnt_q;
  logic          done_q;
  logic [1:0]    status_d, status_q;
  logic [15:0]   dest_d, dest_q, fp_d, fp_q, fe_d, fe_q;
  logic [31:0]   seq_d, seq_q;

  sweep_t sw [TableEntries+1];
  logic [TableEntries-1:0] valid;
  entry_t entries [TableEntries];
  wr_t wr;
  logic finish, accept, root;

  // Seed the sweep at the head of the chain.
  always_comb begin
    sw[0] = '0;
    sw[0].tok = go_q;
    sw[0].best.etx = NoEtx;
  end

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    ctps_cell #(.Idx(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .sweep_i (sw[g]),
      .key_i   (sender_q),
      .wr_i    (wr),
      .sweep_o (sw[g+1]),
      .valid_o (valid[g]),
      .entry_o (entries[g])
    );
  end

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign finish = (state_q == S_SWEEP) && sw[TableEntries].tok;
  assign root   = (self_q == 16'd0);

  // Sequence idle and sweep.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_SWEEP;
      S_SWEEP: if (finish) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Decide the item once the sweep has passed the last cell.
  always_comb begin
    logic [IW-1:0] slot;
    logic          slot_ok;
    logic          usable;
    wr       = '0;
    known_d  = known_q;
    pslot_d  = pslot_q;
    status_d = ST_IGNORED;
    dest_d   = '0;
    seq_d    = '0;
    fp_d     = '0;
    fe_d     = '0;
    slot     = '0;
    slot_ok  = 1'b0;
    usable   = 1'b0;
    unique case (op_q)
      OP_BEACON_RX: begin
        if (sw[TableEntries].hit.vld) begin
          slot = sw[TableEntries].hit.idx[IW-1:0];
          slot_ok = 1'b1;
        end else if (sw[TableEntries].free.vld) begin
          slot = sw[TableEntries].free.idx[IW-1:0];
          slot_ok = 1'b1;
        end else if (sw[TableEntries].worst.vld && sw[TableEntries].worst.etx > adve_q) begin
          slot = sw[TableEntries].worst.idx[IW-1:0];
          slot_ok = 1'b1;
        end
        if (!root && advp_q != NoAddr && adve_q != NoEtx && slot_ok) begin
          wr.en          = finish;
          wr.idx         = IdxW'(slot);
          wr.data.addr   = sender_q;
          wr.data.mac    = mac_q;
          wr.data.parent = advp_q;
          wr.data.etx    = adve_q + 16'd1;
          status_d       = ST_DONE;
        end
      end
      OP_BEACON_TICK: begin
        if (root) begin
          fp_d = self_q;
          fe_d = 16'd0;
        end else begin
          if (sw[TableEntries].best.vld) begin
            known_d = 1'b1;
            pslot_d = sw[TableEntries].best.idx[IW-1:0];
          end else if (known_q && !valid[pslot_q]) begin
            known_d = 1'b0;
          end
          usable = known_d && valid[pslot_d];
          fp_d = usable ? entries[pslot_d].addr : NoAddr;
          fe_d = usable ? entries[pslot_d].etx : NoEtx;
        end
        status_d = ST_DONE;
        dest_d   = NoAddr;
        seq_d    = cnt_q;
      end
      OP_RELAY: begin
        if (!root) begin
          usable = known_q && valid[pslot_q];
          if (usable) begin
            status_d = ST_DONE;
            dest_d   = entries[pslot_q].mac;
          end else begin
            status_d = ST_NO_ROUTE;
          end
        end
      end
      default: status_d = ST_IGNORED;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      go_q    <= 1'b0;
      known_q <= 1'b0;
      pslot_q <= '0;
      cnt_q   <= '0;
      self_q  <= 16'd1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= accept;
      done_q  <= finish;
      if (cfg_we_i) self_q <= cfg_wdata_i;
      if (finish && op_q == OP_BEACON_TICK) begin
        cnt_q   <= cnt_q + 32'd1;
        known_q <= known_d;
        pslot_q <= pslot_d;
      end
    end
  end

  // Capture the item and the result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_e'(operation_i);
      sender_q <= sender_addr_i;
      mac_q    <= src_mac_i;
      advp_q   <= adv_parent_i;
      adve_q   <= adv_etx_i;
    end
    if (finish) begin
      status_q <= status_d;
      dest_q   <= dest_d;
      seq_q    <= seq_d;
      fp_q     <= fp_d;
      fe_q     <= fe_d;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign dest_mac_o     = dest_q;
  assign beacon_seq_o   = seq_q;
  assign frame_parent_o = fp_q;
  assign frame_etx_o    = fe_q;

endmodule
`default_nettype wire

/* rtl/ctps_checker.sv */
`default_nettype none
`include "collection_tree_parent_selector_unit_assert.svh"
module ctps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [15:0] dest_mac_o,
  input logic [31:0] beacon_seq_o
);
  // A taken item keeps the block busy in the next cycle.
  `CTPS_ASSERT(a_busy_after_start, start && !busy |=> busy)
  // Results are spaced apart by the sweep.
  `CTPS_ASSERT(a_single_strobe, done_o |=> !done_o)
  // No result carries the unused status code.
  `CTPS_ASSERT(a_status_code, done_o |-> status_o != 2'd3)
  // Only beacon ticks carry a sequence number, always broadcast.
  `CTPS_ASSERT(a_seq_broadcast, done_o && beacon_seq_o != 32'd0 |-> dest_mac_o == 16'hffff && status_o == 2'd0)
  // Reset leaves no result and no busy item.
  `CTPS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !done_o && !busy)
endmodule

bind collection_tree_parent_selector_unit ctps_checker u_ctps_checker (.*);
`default_nettype wire
